// File: rtl/diff_drive_pose_integrator_assert.svh
// ---------------------------------------------------------------------------
// diff drive pose integrator assertion macros
// concurrent checks that compile to nothing in synthesis builds
// ---------------------------------------------------------------------------
`ifndef DIFF_DRIVE_POSE_INTEGRATOR_ASSERT_SVH
`define DIFF_DRIVE_POSE_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define DPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpi check failed");
`define DPI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpi check failed");
`else
`define DPI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DPI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/dpi_pkg.sv
// ---------------------------------------------------------------------------
// dpi_pkg
// shared types, constants and helpers of the pose integrator
// ---------------------------------------------------------------------------
package dpi_pkg;

    localparam int CordicStepsDef = 24;
    localparam int CorW           = 34;
    localparam int DivNumW        = 60;
    localparam int DivDenW        = 40;

    localparam logic signed [CorW-1:0] GainQ30 = 34'sd652032874;
    localparam logic [29:0]            RadToBa = 30'd683565276;
    localparam logic [16:0]            MarginQ16 = 17'd655;
    localparam logic [16:0]            FracOne   = 17'd65536;
    localparam logic [15:0]            RadiusRst = 16'd66;
    localparam logic [19:0]            BaseRst   = 20'd66;

    typedef enum logic [0:0] {
        REG_WHEEL_RADIUS = 1'b0,
        REG_WHEEL_BASE   = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        OPN_INTEGRATE = 1'b0,
        OPN_LOAD      = 1'b1
    } operation_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_LOAD, OP_VSUM, OP_VDIF, OP_TIME, OP_TURN,
        OP_DIST, OP_SAVE, OP_SX, OP_SY, OP_PROD, OP_RBLO, OP_RBHI, OP_COR1,
        OP_COR2, OP_NUMX, OP_DIVX, OP_DX, OP_NUMY, OP_DIVY, OP_DY, OP_POSE,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_VSUM, S_LOAD, S_VDIF, S_TIME, S_DIV_T, S_BRANCH, S_DIST,
        S_COR_S, S_SX, S_SY, S_PROD, S_RBLO, S_RBHI, S_COR_A, S_COR_B,
        S_NUMX, S_DIVX, S_WAIT_X, S_NUMY, S_DIVY, S_WAIT_Y, S_POSE, S_OUT
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic turn_zero;
        logic div_done;
        logic cor_done;
    } status_t;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)
            return 24'sh7fffff;
        else if (v < -64'sd8388608)
            return 24'sh800000;
        else
            return $signed(v[23:0]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return $signed(v[31:0]);
    endfunction

    function automatic logic [31:0] atan_ba(input logic [4:0] i);
        case (i)
            5'd0:    return 32'd536870912;
            5'd1:    return 32'd316933406;
            5'd2:    return 32'd167458907;
            5'd3:    return 32'd85004756;
            5'd4:    return 32'd42667331;
            5'd5:    return 32'd21354465;
            5'd6:    return 32'd10679838;
            5'd7:    return 32'd5340245;
            5'd8:    return 32'd2670163;
            5'd9:    return 32'd1335087;
            5'd10:   return 32'd667544;
            5'd11:   return 32'd333772;
            5'd12:   return 32'd166886;
            5'd13:   return 32'd83443;
            5'd14:   return 32'd41722;
            5'd15:   return 32'd20861;
            5'd16:   return 32'd10430;
            5'd17:   return 32'd5215;
            5'd18:   return 32'd2608;
            5'd19:   return 32'd1304;
            5'd20:   return 32'd652;
            5'd21:   return 32'd326;
            5'd22:   return 32'd163;
            5'd23:   return 32'd81;
            5'd24:   return 32'd41;
            5'd25:   return 32'd20;
            5'd26:   return 32'd10;
            5'd27:   return 32'd5;
            5'd28:   return 32'd3;
            5'd29:   return 32'd1;
            5'd30:   return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

endpackage

// File: rtl/dpi_div.sv
// ---------------------------------------------------------------------------
// dpi_div
// signed restoring divider, one quotient bit per cycle, truncates to zero
// ---------------------------------------------------------------------------
module dpi_div #(
    parameter int NumW = dpi_pkg::DivNumW,
    parameter int DenW = dpi_pkg::DivDenW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [NumW-1:0] num,
    input  logic signed [DenW-1:0] den,
    output logic signed [NumW-1:0] quot,
    output logic                   done
);

    localparam int CntW = $clog2(NumW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    logic [DenW-1:0] rem_reg;
    logic [NumW-1:0] quo_reg;
    logic [DenW-1:0] dmag_reg;
    logic            neg_reg;
    logic [DenW:0]   trial;
    logic            fits;

    assign trial = {rem_reg, quo_reg[NumW-1]};
    assign fits  = trial >= {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CntW'(NumW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= num[NumW-1] ? NumW'(-num) : NumW'(num);
            dmag_reg <= den[DenW-1] ? DenW'(-den) : DenW'(den);
            neg_reg  <= num[NumW-1] ^ den[DenW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DenW'(trial - {1'b0, dmag_reg}) : trial[DenW-1:0];
            quo_reg <= {quo_reg[NumW-2:0], fits};
        end
    end

    assign quot = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign done = done_reg;

endmodule

// File: rtl/dpi_cordic.sv
// ---------------------------------------------------------------------------
// dpi_cordic
// iterative rotation cordic, binary angle in, cosine and sine out in q4.30
// ---------------------------------------------------------------------------
module dpi_cordic #(
    parameter int CORDIC_STEPS = dpi_pkg::CordicStepsDef
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [31:0]                     angle,
    output logic signed [dpi_pkg::CorW-1:0] cos_val,
    output logic signed [dpi_pkg::CorW-1:0] sin_val,
    output logic                            done
);

    localparam int         W    = dpi_pkg::CorW;
    localparam logic [4:0] Last = 5'(CORDIC_STEPS - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [4:0]          idx_reg;
    logic signed [W-1:0] x_reg;
    logic signed [W-1:0] y_reg;
    logic signed [W-1:0] z_reg;
    logic                flip_reg;
    logic                flip;
    logic [31:0]         folded;
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] at;

    assign flip   = (angle + 32'h4000_0000) >> 31 != 32'd0;
    assign folded = flip ? angle + 32'h8000_0000 : angle;
    assign xs     = x_reg >>> idx_reg;
    assign ys     = y_reg >>> idx_reg;
    assign at     = $signed({2'b00, dpi_pkg::atan_ba(idx_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (busy_reg)
        begin
            idx_reg <= idx_reg + 5'd1;
            if (idx_reg == Last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= dpi_pkg::GainQ30;
            y_reg    <= '0;
            z_reg    <= W'($signed(folded));
            flip_reg <= flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;
    assign done    = done_reg;

endmodule

// File: rtl/dpi_datapath.sv
// ---------------------------------------------------------------------------
// dpi_datapath
// operand registers, pose state, multiplies and the shared divider and cordic
// ---------------------------------------------------------------------------
module dpi_datapath #(
    parameter int CORDIC_STEPS = dpi_pkg::CordicStepsDef
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpi_pkg::cmd_t        cmd,
    output dpi_pkg::status_t     status,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [19:0]          cfg_data,
    input  logic [0:0]           operation,
    input  logic signed [23:0]   left_wheel_speed,
    input  logic signed [23:0]   right_wheel_speed,
    input  logic [23:0]          step_time,
    input  logic                 collided,
    input  logic [16:0]          collision_fraction,
    input  logic signed [31:0]   load_x,
    input  logic signed [31:0]   load_y,
    input  logic [31:0]          load_heading,
    output logic signed [31:0]   new_x,
    output logic signed [31:0]   new_y,
    output logic [31:0]          new_heading,
    output logic signed [23:0]   linear_speed,
    output logic signed [23:0]   turn_rate
);

    localparam int CW = dpi_pkg::CorW;
    localparam int NW = dpi_pkg::DivNumW;
    localparam int DW = dpi_pkg::DivDenW;

    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                     input int n);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< n) - 64'sd1) : 64'sd0;
        return (v + bias) >>> n;
    endfunction

    dpi_pkg::operation_t op_reg;
    logic signed [23:0]  wl_reg;
    logic signed [23:0]  wr_reg;
    logic [23:0]         st_reg;
    logic                col_reg;
    logic [16:0]         cf_reg;
    logic signed [31:0]  lx_reg;
    logic signed [31:0]  ly_reg;
    logic [31:0]         lh_reg;

    logic [15:0]         radius_reg;
    logic [19:0]         base_reg;
    logic signed [31:0]  pose_x_reg;
    logic signed [31:0]  pose_y_reg;
    logic [31:0]         heading_reg;

    logic signed [41:0]  vsum_reg;
    logic signed [41:0]  vdif_reg;
    logic signed [23:0]  lin_reg;
    logic signed [23:0]  turn_reg;
    logic [28:0]         t_reg;
    logic signed [29:0]  d_reg;
    logic [52:0]         mag_reg;
    logic                neg_reg;
    logic [61:0]         acc_reg;
    logic [31:0]         h2_reg;
    logic signed [CW-1:0] c1_reg;
    logic signed [CW-1:0] s1_reg;
    logic signed [CW-1:0] c2_reg;
    logic signed [CW-1:0] s2_reg;
    logic signed [NW-1:0] num_reg;
    logic signed [NW-1:0] dx_reg;
    logic signed [NW-1:0] dy_reg;

    logic signed [31:0]  out_x_reg;
    logic signed [31:0]  out_y_reg;
    logic [31:0]         out_h_reg;
    logic signed [23:0]  out_lin_reg;
    logic signed [23:0]  out_turn_reg;

    logic signed [24:0]  wsum;
    logic signed [24:0]  wdif;
    logic signed [41:0]  rad_s;
    logic [16:0]         frac;
    logic [40:0]         tprod;
    logic signed [29:0]  t_s;
    logic signed [53:0]  lt_prod;
    logic signed [53:0]  tt_prod;
    logic signed [63:0]  dc_prod;
    logic signed [63:0]  ds_prod;
    logic [51:0]         hi_part;
    logic [31:0]         dba;
    logic signed [CW:0]  sdiff;
    logic signed [CW:0]  cdiff;
    logic signed [19:0]  base_eff;

    logic                 div_start;
    logic signed [NW-1:0] div_num;
    logic signed [DW-1:0] div_den;
    logic signed [NW-1:0] div_q;
    logic                 div_done;
    logic                 cor_start;
    logic [31:0]          cor_angle;
    logic signed [CW-1:0] cor_c;
    logic signed [CW-1:0] cor_s;
    logic                 cor_done;

    assign wsum     = 25'(wr_reg) + 25'(wl_reg);
    assign wdif     = 25'(wr_reg) - 25'(wl_reg);
    assign rad_s    = 42'($signed({1'b0, radius_reg}));
    assign frac     = !col_reg ? dpi_pkg::FracOne :
                      (cf_reg > dpi_pkg::MarginQ16 ? cf_reg - dpi_pkg::MarginQ16 : 17'd0);
    assign tprod    = 41'(st_reg) * 41'(frac);
    assign t_s      = $signed({1'b0, t_reg});
    assign lt_prod  = 54'(lin_reg) * 54'(t_s);
    assign tt_prod  = 54'(turn_reg) * 54'(t_s);
    assign dc_prod  = 64'(d_reg) * 64'(c1_reg);
    assign ds_prod  = 64'(d_reg) * 64'(s1_reg);
    assign hi_part  = 52'(mag_reg[52:32]) * 52'(dpi_pkg::RadToBa) + 52'(acc_reg[61:32]);
    assign dba      = hi_part[39:8];
    assign sdiff    = (CW+1)'(s2_reg) - (CW+1)'(s1_reg);
    assign cdiff    = (CW+1)'(c1_reg) - (CW+1)'(c2_reg);
    assign base_eff = (base_reg == 20'd0) ? 20'sd1 : $signed(base_reg);

    assign div_start = cmd.op == dpi_pkg::OP_TIME || cmd.op == dpi_pkg::OP_DIVX ||
                       cmd.op == dpi_pkg::OP_DIVY;
    assign div_num   = (cmd.op == dpi_pkg::OP_TIME) ? NW'(vdif_reg) : num_reg;
    assign div_den   = (cmd.op == dpi_pkg::OP_TIME) ? DW'($signed({1'b0, base_eff})) :
                       DW'($signed({turn_reg, 14'd0}));
    assign cor_start = cmd.op == dpi_pkg::OP_DIST || cmd.op == dpi_pkg::OP_RBHI ||
                       cmd.op == dpi_pkg::OP_COR1;
    assign cor_angle = (cmd.op == dpi_pkg::OP_COR1) ? h2_reg : heading_reg;

    dpi_div #(
        .NumW (NW),
        .DenW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_q),
        .done  (div_done)
    );

    dpi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .cos_val (cor_c),
        .sin_val (cor_s),
        .done    (cor_done)
    );

    // configuration and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= dpi_pkg::RadiusRst;
            base_reg    <= dpi_pkg::BaseRst;
            pose_x_reg  <= '0;
            pose_y_reg  <= '0;
            heading_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (dpi_pkg::reg_idx_t'(cfg_index))
                    dpi_pkg::REG_WHEEL_RADIUS: radius_reg <= cfg_data[15:0];
                    dpi_pkg::REG_WHEEL_BASE:   base_reg   <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                dpi_pkg::OP_LOAD:
                begin
                    pose_x_reg  <= lx_reg;
                    pose_y_reg  <= ly_reg;
                    heading_reg <= lh_reg;
                end
                dpi_pkg::OP_DY:   heading_reg <= h2_reg;
                dpi_pkg::OP_POSE:
                begin
                    pose_x_reg <= dpi_pkg::sat32(64'(pose_x_reg) + 64'(dx_reg));
                    pose_y_reg <= dpi_pkg::sat32(64'(pose_y_reg) + 64'(dy_reg));
                end
                default: ;
            endcase
        end
    end

    // operands and intermediate results
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            dpi_pkg::OP_CAPTURE:
            begin
                op_reg <= dpi_pkg::operation_t'(operation);
                wl_reg <= left_wheel_speed;
                wr_reg <= right_wheel_speed;
                st_reg <= step_time;
                col_reg <= collided;
                cf_reg <= collision_fraction;
                lx_reg <= load_x;
                ly_reg <= load_y;
                lh_reg <= load_heading;
            end
            dpi_pkg::OP_LOAD:
            begin
                lin_reg  <= '0;
                turn_reg <= '0;
            end
            dpi_pkg::OP_VSUM: vsum_reg <= 42'(wsum) * rad_s;
            dpi_pkg::OP_VDIF:
            begin
                vdif_reg <= 42'(wdif) * rad_s;
                lin_reg  <= dpi_pkg::sat24(trunc_shr(64'(vsum_reg), 17));
            end
            dpi_pkg::OP_TIME: t_reg <= tprod[40:12];
            dpi_pkg::OP_TURN: turn_reg <= dpi_pkg::sat24(64'(div_q));
            dpi_pkg::OP_DIST: d_reg <= 30'(trunc_shr(64'(lt_prod), 24));
            dpi_pkg::OP_SAVE:
            begin
                c1_reg <= cor_c;
                s1_reg <= cor_s;
            end
            dpi_pkg::OP_SX: dx_reg <= NW'(trunc_shr(dc_prod, 30));
            dpi_pkg::OP_SY: dy_reg <= NW'(trunc_shr(ds_prod, 30));
            dpi_pkg::OP_PROD:
            begin
                neg_reg <= tt_prod[53];
                mag_reg <= tt_prod[53] ? 53'(-tt_prod) : 53'(tt_prod);
            end
            dpi_pkg::OP_RBLO: acc_reg <= 62'(mag_reg[31:0]) * 62'(dpi_pkg::RadToBa);
            dpi_pkg::OP_RBHI: h2_reg <= heading_reg + (neg_reg ? 32'd0 - dba : dba);
            dpi_pkg::OP_COR1:
            begin
                c1_reg <= cor_c;
                s1_reg <= cor_s;
            end
            dpi_pkg::OP_COR2:
            begin
                c2_reg <= cor_c;
                s2_reg <= cor_s;
            end
            dpi_pkg::OP_NUMX: num_reg <= NW'(sdiff) * NW'(lin_reg);
            dpi_pkg::OP_DX:   dx_reg  <= div_q;
            dpi_pkg::OP_NUMY: num_reg <= NW'(cdiff) * NW'(lin_reg);
            dpi_pkg::OP_DY:   dy_reg  <= div_q;
            dpi_pkg::OP_OUT:
            begin
                out_x_reg    <= pose_x_reg;
                out_y_reg    <= pose_y_reg;
                out_h_reg    <= heading_reg;
                out_lin_reg  <= lin_reg;
                out_turn_reg <= turn_reg;
            end
            default: ;
        endcase
    end

    assign status.is_load   = op_reg == dpi_pkg::OPN_LOAD;
    assign status.turn_zero = turn_reg == 24'sd0;
    assign status.div_done  = div_done;
    assign status.cor_done  = cor_done;

    assign new_x        = out_x_reg;
    assign new_y        = out_y_reg;
    assign new_heading  = out_h_reg;
    assign linear_speed = out_lin_reg;
    assign turn_rate    = out_turn_reg;

endmodule

// File: rtl/dpi_ctrl.sv
// ---------------------------------------------------------------------------
// dpi_ctrl
// sequencer for one request, owns the handshakes and the result valid flag
// ---------------------------------------------------------------------------
module dpi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  dpi_pkg::status_t status,
    output dpi_pkg::cmd_t    cmd
);

    dpi_pkg::state_t state_reg;
    dpi_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpi_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = dpi_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            dpi_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = dpi_pkg::OP_CAPTURE;
                    state_next = dpi_pkg::S_VSUM;
                end
            end
            dpi_pkg::S_VSUM:
            begin
                cmd.op     = dpi_pkg::OP_VSUM;
                state_next = status.is_load ? dpi_pkg::S_LOAD : dpi_pkg::S_VDIF;
            end
            dpi_pkg::S_LOAD:
            begin
                cmd.op     = dpi_pkg::OP_LOAD;
                state_next = dpi_pkg::S_OUT;
            end
            dpi_pkg::S_VDIF:
            begin
                cmd.op     = dpi_pkg::OP_VDIF;
                state_next = dpi_pkg::S_TIME;
            end
            dpi_pkg::S_TIME:
            begin
                cmd.op     = dpi_pkg::OP_TIME;
                state_next = dpi_pkg::S_DIV_T;
            end
            dpi_pkg::S_DIV_T:
            begin
                if (status.div_done)
                begin
                    cmd.op     = dpi_pkg::OP_TURN;
                    state_next = dpi_pkg::S_BRANCH;
                end
            end
            dpi_pkg::S_BRANCH:
                state_next = status.turn_zero ? dpi_pkg::S_DIST : dpi_pkg::S_PROD;
            // straight path
            dpi_pkg::S_DIST:
            begin
                cmd.op     = dpi_pkg::OP_DIST;
                state_next = dpi_pkg::S_COR_S;
            end
            dpi_pkg::S_COR_S:
            begin
                if (status.cor_done)
                begin
                    cmd.op     = dpi_pkg::OP_SAVE;
                    state_next = dpi_pkg::S_SX;
                end
            end
            dpi_pkg::S_SX:
            begin
                cmd.op     = dpi_pkg::OP_SX;
                state_next = dpi_pkg::S_SY;
            end
            dpi_pkg::S_SY:
            begin
                cmd.op     = dpi_pkg::OP_SY;
                state_next = dpi_pkg::S_POSE;
            end
            // arc path
            dpi_pkg::S_PROD:
            begin
                cmd.op     = dpi_pkg::OP_PROD;
                state_next = dpi_pkg::S_RBLO;
            end
            dpi_pkg::S_RBLO:
            begin
                cmd.op     = dpi_pkg::OP_RBLO;
                state_next = dpi_pkg::S_RBHI;
            end
            dpi_pkg::S_RBHI:
            begin
                cmd.op     = dpi_pkg::OP_RBHI;
                state_next = dpi_pkg::S_COR_A;
            end
            dpi_pkg::S_COR_A:
            begin
                if (status.cor_done)
                begin
                    cmd.op     = dpi_pkg::OP_COR1;
                    state_next = dpi_pkg::S_COR_B;
                end
            end
            dpi_pkg::S_COR_B:
            begin
                if (status.cor_done)
                begin
                    cmd.op     = dpi_pkg::OP_COR2;
                    state_next = dpi_pkg::S_NUMX;
                end
            end
            dpi_pkg::S_NUMX:
            begin
                cmd.op     = dpi_pkg::OP_NUMX;
                state_next = dpi_pkg::S_DIVX;
            end
            dpi_pkg::S_DIVX:
            begin
                cmd.op     = dpi_pkg::OP_DIVX;
                state_next = dpi_pkg::S_WAIT_X;
            end
            dpi_pkg::S_WAIT_X:
            begin
                if (status.div_done)
                begin
                    cmd.op     = dpi_pkg::OP_DX;
                    state_next = dpi_pkg::S_NUMY;
                end
            end
            dpi_pkg::S_NUMY:
            begin
                cmd.op     = dpi_pkg::OP_NUMY;
                state_next = dpi_pkg::S_DIVY;
            end
            dpi_pkg::S_DIVY:
            begin
                cmd.op     = dpi_pkg::OP_DIVY;
                state_next = dpi_pkg::S_WAIT_Y;
            end
            dpi_pkg::S_WAIT_Y:
            begin
                if (status.div_done)
                begin
                    cmd.op     = dpi_pkg::OP_DY;
                    state_next = dpi_pkg::S_POSE;
                end
            end
            dpi_pkg::S_POSE:
            begin
                cmd.op     = dpi_pkg::OP_POSE;
                state_next = dpi_pkg::S_OUT;
            end
            dpi_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op     = dpi_pkg::OP_OUT;
                    state_next = dpi_pkg::S_IDLE;
                end
            end
            default:
                state_next = dpi_pkg::S_IDLE;
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || (cmd.op == dpi_pkg::OP_OUT);
    assign out_valid      = out_valid_reg;

endmodule

// File: rtl/diff_drive_pose_integrator.sv
// ---------------------------------------------------------------------------
// diff_drive_pose_integrator
// differential drive odometry with exact arc pose update in fixed point
// ---------------------------------------------------------------------------
// One request at a time. A pose load uses neither the divider nor the cordic
// unit. The time an integrate step takes is set by the shared divider, which
// yields one quotient bit per cycle over 60 bits and runs once for the turn
// rate and twice for the arc displacement, and by the shared cordic unit, one
// rotation step per cycle, run once on a straight path and twice on an arc.
// A finished result waits in the output register while the next request is
// taken. Configuration writes are always accepted.
`include "diff_drive_pose_integrator_assert.svh"

module diff_drive_pose_integrator #(
    parameter int CORDIC_STEPS = dpi_pkg::CordicStepsDef
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // left_wheel_speed, right_wheel_speed, step_time, collided,
    // collision_fraction, load_x, load_y, load_heading, zero fill
    input  logic [191:0] s_axis_tdata,
    // operation
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_x, new_y, new_heading, linear_speed, turn_rate
    output logic [143:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [19:0]  cfg_data
);

    dpi_pkg::cmd_t    cmd;
    dpi_pkg::status_t status;

    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic [31:0]        new_heading;
    logic signed [23:0] linear_speed;
    logic signed [23:0] turn_rate;

    assign cfg_ready = 1'b1;

    dpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    dpi_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .operation          (s_axis_tuser),
        .left_wheel_speed   ($signed(s_axis_tdata[23:0])),
        .right_wheel_speed  ($signed(s_axis_tdata[47:24])),
        .step_time          (s_axis_tdata[71:48]),
        .collided           (s_axis_tdata[72]),
        .collision_fraction (s_axis_tdata[89:73]),
        .load_x             ($signed(s_axis_tdata[121:90])),
        .load_y             ($signed(s_axis_tdata[153:122])),
        .load_heading       (s_axis_tdata[185:154]),
        .new_x              (new_x),
        .new_y              (new_y),
        .new_heading        (new_heading),
        .linear_speed       (linear_speed),
        .turn_rate          (turn_rate)
    );

    assign m_axis_tdata = {turn_rate, linear_speed, new_heading, new_y, new_x};

    `DPI_ASSERT_NXT(a_busy_after_request, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `DPI_ASSERT_IMP(a_result_at_idle, clk, rst_n, $rose(m_axis_tvalid), s_axis_tready)

endmodule
